// ===== design/assert_macros.svh =====
// Assertion macros shared by the MTC generator modules.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/mtc_pkg.sv =====
// Types, constants and timecode arithmetic for the MTC generator.
// No dependencies; used by mtc_msg_sender and mtc_quarter_frame_generator.
package mtc_pkg;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [4:0] frames;
    } t_tc;

    // One outgoing message: full-frame SysEx or a two-byte quarter frame.
    typedef struct packed {
        logic       full;
        logic [7:0] d0;
        logic [7:0] d1;
        logic [7:0] d2;
        logic [7:0] d3;
    } t_msg;

    localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
    localparam logic [7:0] BYTE_UNIVERSAL_RT = 8'h7F;
    localparam logic [7:0] BYTE_MTC_SUB_ID = 8'h01;
    localparam logic [7:0] BYTE_SYSEX_END = 8'hF7;
    localparam logic [7:0] BYTE_QF_STATUS = 8'hF1;

    localparam logic [1:0] RATE_24 = 2'd0;
    localparam logic [1:0] RATE_25 = 2'd1;
    localparam logic [1:0] RATE_30_DROP = 2'd2;
    localparam logic [1:0] RATE_30 = 2'd3;

    localparam logic [1:0] CFG_RATE = 2'd0;
    localparam logic [1:0] CFG_PERIOD = 2'd1;
    localparam logic [1:0] CFG_QF_EN = 2'd2;

    localparam logic [1:0]  RESET_RATE = RATE_25;
    localparam logic [23:0] RESET_PERIOD = 24'd122880;

    localparam logic [23:0] PHASE_STEP = 24'd256;

    localparam logic [2:0] PIECE_FRAMES_LO = 3'd0;
    localparam logic [2:0] PIECE_FRAMES_HI = 3'd1;
    localparam logic [2:0] PIECE_SECONDS_LO = 3'd2;
    localparam logic [2:0] PIECE_SECONDS_HI = 3'd3;
    localparam logic [2:0] PIECE_MINUTES_LO = 3'd4;
    localparam logic [2:0] PIECE_MINUTES_HI = 3'd5;
    localparam logic [2:0] PIECE_HOURS_LO = 3'd6;
    localparam logic [2:0] PIECE_RATE_HOURS = 3'd7;

    localparam logic [3:0] FULL_LAST_IDX = 4'd9;
    localparam logic [3:0] QF_LAST_IDX = 4'd1;

    // Minute is a multiple of ten (0..63 range).
    function automatic logic is_tens(input logic [5:0] m);
        return (m == 6'd0) || (m == 6'd10) || (m == 6'd20) || (m == 6'd30) ||
               (m == 6'd40) || (m == 6'd50) || (m == 6'd60);
    endfunction

    // Advance the timecode by one frame with rate-dependent wrapping.
    function automatic t_tc tc_advance(input logic [1:0] rate, input t_tc tc);
        t_tc        n;
        logic [4:0] fps;
        n = tc;
        case (rate)
            RATE_24: fps = 5'd24;
            RATE_25: fps = 5'd25;
            default: fps = 5'd30;
        endcase
        n.frames = tc.frames + 5'd1;
        if (n.frames >= fps) begin
            n.frames  = 5'd0;
            n.seconds = tc.seconds + 6'd1;
            if (n.seconds >= 6'd60) begin
                n.seconds = 6'd0;
                n.minutes = tc.minutes + 6'd1;
                if (n.minutes >= 6'd60) begin
                    n.minutes = 6'd0;
                    n.hours   = tc.hours + 5'd1;
                    if (n.hours >= 5'd24) begin
                        n.hours = 5'd0;
                    end
                end
            end
            // drop frames 0 and 1 at each minute not divisible by ten
            if (rate == RATE_30_DROP && n.seconds == 6'd0 && !is_tens(n.minutes)) begin
                n.frames = 5'd2;
            end
        end
        return n;
    endfunction

endpackage

// ===== design/mtc_msg_sender.sv =====
// Output sequencer: walks one stored message out a byte per transfer.
// Depends on mtc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mtc_msg_sender (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  mtc_pkg::t_msg i_msg,
    output logic          o_free,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [7:0]    o_midi_byte,
    output logic          o_last
);

    logic          r_valid;
    logic [3:0]    r_idx;
    mtc_pkg::t_msg r_msg;
    logic          n_valid;
    logic [3:0]    n_idx;

    assign o_valid = r_valid;
    assign o_last  = r_msg.full ? (r_idx == mtc_pkg::FULL_LAST_IDX)
                                : (r_idx == mtc_pkg::QF_LAST_IDX);
    // free when empty or when the final byte leaves this cycle
    assign o_free  = !r_valid || (!i_stall && o_last);

    always_comb begin
        if (r_msg.full) begin
            case (r_idx)
                4'd0:    o_midi_byte = mtc_pkg::BYTE_SYSEX_START;
                4'd1:    o_midi_byte = mtc_pkg::BYTE_UNIVERSAL_RT;
                4'd2:    o_midi_byte = mtc_pkg::BYTE_UNIVERSAL_RT;
                4'd3:    o_midi_byte = mtc_pkg::BYTE_MTC_SUB_ID;
                4'd4:    o_midi_byte = mtc_pkg::BYTE_MTC_SUB_ID;
                4'd5:    o_midi_byte = r_msg.d0;
                4'd6:    o_midi_byte = r_msg.d1;
                4'd7:    o_midi_byte = r_msg.d2;
                4'd8:    o_midi_byte = r_msg.d3;
                default: o_midi_byte = mtc_pkg::BYTE_SYSEX_END;
            endcase
        end else begin
            o_midi_byte = (r_idx == 4'd0) ? mtc_pkg::BYTE_QF_STATUS : r_msg.d0;
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (i_load) begin
            n_valid = 1'b1;
            n_idx   = 4'd0;
        end else if (r_valid && !i_stall) begin
            if (o_last) begin
                n_valid = 1'b0;
            end else begin
                n_idx = r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 4'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_msg <= i_msg;
        end
    end

    `ASSERT_IMPLY(a_idx_in_range, i_clk, i_rst_n, 1'b1, r_idx <= mtc_pkg::FULL_LAST_IDX)
    `ASSERT_IMPLY(a_qf_two_bytes, i_clk, i_rst_n, r_valid && !r_msg.full, r_idx <= mtc_pkg::QF_LAST_IDX)
    `ASSERT_IMPLY(a_load_when_free, i_clk, i_rst_n, i_load, o_free)

endmodule

// ===== design/mtc_quarter_frame_generator.sv =====
// MIDI time code generator: full-frame SysEx on load, quarter frames on ticks.
// Latency: first byte of a message is valid the cycle after its input transfer
// when the sender is free, else the cycle after the sender frees up.
// Throughput: one input item per cycle while the pending message slot is free;
// output runs one byte per cycle unless stalled (10 per full frame, 2 per quarter frame).
// Reset (synchronous, active low) clears timecode, phase, piece and running,
// and returns the registers to 25 fps, default period, quarter frames off.
// Depends on mtc_pkg, mtc_msg_sender and assert_macros.svh.
`include "assert_macros.svh"

module mtc_quarter_frame_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [4:0]  i_tc_hours,
    input  logic [5:0]  i_tc_minutes,
    input  logic [5:0]  i_tc_seconds,
    input  logic [4:0]  i_tc_frames,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_midi_byte,
    output logic        o_last
);

    logic [1:0]    r_rate;
    logic [23:0]   r_period;
    logic          r_qf_en;

    mtc_pkg::t_tc  r_tc;
    logic [2:0]    r_piece;
    logic [23:0]   r_phase;
    logic          r_running;
    logic          r_pend_valid;
    mtc_pkg::t_msg r_pend;

    logic          acc;
    logic          qf_active;
    logic          emit;
    logic [4:0]    hr_mod;
    mtc_pkg::t_tc  load_tc;
    mtc_pkg::t_tc  load_adj;
    mtc_pkg::t_tc  tc_group;
    logic [6:0]    hrbits;
    logic [3:0]    nib;
    logic [23:0]   period;
    logic [23:0]   phase_next;
    logic          new_valid;
    mtc_pkg::t_msg new_msg;
    logic          send_free;
    logic          send_load;
    mtc_pkg::t_msg send_msg;

    assign o_in_stall = r_pend_valid;
    assign acc        = i_in_valid && !o_in_stall;

    // load path: hours mod 24, then align to an even frame except at 25 fps
    assign hr_mod   = (i_tc_hours >= 5'd24) ? (i_tc_hours - 5'd24) : i_tc_hours;
    assign load_tc  = '{hours: hr_mod, minutes: i_tc_minutes,
                        seconds: i_tc_seconds, frames: i_tc_frames};
    assign load_adj = (r_rate != mtc_pkg::RATE_25 && i_tc_frames[0])
                    ? mtc_pkg::tc_advance(r_rate, load_tc) : load_tc;

    // tick path
    assign qf_active  = r_running && r_qf_en;
    assign emit       = qf_active && (r_phase[23:8] == 16'd0);
    assign hrbits     = {r_rate, r_tc.hours};
    assign tc_group   = mtc_pkg::tc_advance(r_rate, mtc_pkg::tc_advance(r_rate, r_tc));
    assign period     = (r_period[23:8] == 16'd0) ? mtc_pkg::PHASE_STEP : r_period;
    assign phase_next = r_phase + (emit ? period : 24'd0) - mtc_pkg::PHASE_STEP;

    always_comb begin
        case (r_piece)
            mtc_pkg::PIECE_FRAMES_LO:  nib = r_tc.frames[3:0];
            mtc_pkg::PIECE_FRAMES_HI:  nib = {3'd0, r_tc.frames[4]};
            mtc_pkg::PIECE_SECONDS_LO: nib = r_tc.seconds[3:0];
            mtc_pkg::PIECE_SECONDS_HI: nib = {2'd0, r_tc.seconds[5:4]};
            mtc_pkg::PIECE_MINUTES_LO: nib = r_tc.minutes[3:0];
            mtc_pkg::PIECE_MINUTES_HI: nib = {2'd0, r_tc.minutes[5:4]};
            mtc_pkg::PIECE_HOURS_LO:   nib = hrbits[3:0];
            default:                   nib = {1'b0, hrbits[6:4]};
        endcase
    end

    assign new_valid = acc && (i_mode || emit);

    always_comb begin
        new_msg = '0;
        if (i_mode) begin
            new_msg.full = 1'b1;
            new_msg.d0   = {1'b0, r_rate, hr_mod};
            new_msg.d1   = {2'd0, i_tc_minutes};
            new_msg.d2   = {2'd0, i_tc_seconds};
            new_msg.d3   = {3'd0, i_tc_frames};
        end else begin
            new_msg.d0   = {1'b0, r_piece, nib};
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate   <= mtc_pkg::RESET_RATE;
            r_period <= mtc_pkg::RESET_PERIOD;
            r_qf_en  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mtc_pkg::CFG_RATE:   r_rate   <= i_cfg_data[1:0];
                mtc_pkg::CFG_PERIOD: r_period <= i_cfg_data;
                mtc_pkg::CFG_QF_EN:  r_qf_en  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // timecode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc      <= '0;
            r_piece   <= 3'd0;
            r_phase   <= 24'd0;
            r_running <= 1'b0;
        end else if (acc) begin
            if (i_mode) begin
                r_tc      <= load_adj;
                r_piece   <= 3'd0;
                r_phase   <= 24'd0;
                r_running <= 1'b1;
            end else if (qf_active) begin
                r_phase <= phase_next;
                if (emit) begin
                    r_piece <= r_piece + 3'd1;
                    // last piece of a group: advance two frames
                    if (r_piece == mtc_pkg::PIECE_RATE_HOURS) begin
                        r_tc <= tc_group;
                    end
                end
            end
        end
    end

    // pending slot in front of the sender
    assign send_load = send_free && (r_pend_valid || new_valid);
    assign send_msg  = r_pend_valid ? r_pend : new_msg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (r_pend_valid) begin
            if (send_free) begin
                r_pend_valid <= 1'b0;
            end
        end else if (new_valid && !send_free) begin
            r_pend_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_pend_valid && new_valid && !send_free) begin
            r_pend <= new_msg;
        end
    end

    mtc_msg_sender u_sender (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (send_load),
        .i_msg       (send_msg),
        .o_free      (send_free),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_midi_byte (o_midi_byte),
        .o_last      (o_last)
    );

    `ASSERT_IMPLY(a_pend_implies_busy, i_clk, i_rst_n, r_pend_valid, o_out_valid)
    `ASSERT_NEXT(a_load_restarts, i_clk, i_rst_n, acc && i_mode, r_running && r_piece == 3'd0 && r_phase == 24'd0)
    `ASSERT_NEXT(a_piece_steps, i_clk, i_rst_n, acc && !i_mode && emit, r_piece == $past(r_piece) + 3'd1)

endmodule

// ===== tb/mtc_quarter_frame_generator_test.sv =====
// Self-checking bench for the MTC generator: full-frame SysEx on load and quarter frames on ticks.
// A scoreboard class predicts every byte; bursty input and patterned output stall drive the block.
// Depends on mtc_pkg and mtc_quarter_frame_generator.
module mtc_quarter_frame_generator_test;
    import mtc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 16;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_mode = 1'b0;
    logic [4:0]  i_tc_hours = '0;
    logic [5:0]  i_tc_minutes = '0;
    logic [5:0]  i_tc_seconds = '0;
    logic [4:0]  i_tc_frames = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_midi_byte;
    logic        o_last;

    typedef struct {
        logic [7:0] midi_byte;
        logic       last;
    } t_mtc_byte;

    class timecode_scoreboard;
        logic [1:0]  rate;
        logic [23:0] period;
        logic        qf_en;
        t_tc         tc;
        logic [2:0]  piece;
        logic [23:0] phase;
        logic        running;
        t_mtc_byte   pending_bytes[$];
        int          errors;
        int          loads;
        int          quarter_frames;
        int          bytes_checked;

        function new();
            rate = RESET_RATE;
            period = RESET_PERIOD;
            qf_en = 1'b0;
            tc = '0;
            piece = '0;
            phase = '0;
            running = 1'b0;
            errors = 0;
            loads = 0;
            quarter_frames = 0;
            bytes_checked = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [23:0] data);
            case (idx)
                CFG_RATE:   rate = data[1:0];
                CFG_PERIOD: period = data;
                CFG_QF_EN:  qf_en = data[0];
                default: ;
            endcase
        endfunction

        function void push_byte(logic [7:0] b, logic l);
            t_mtc_byte e;
            e.midi_byte = b;
            e.last = l;
            pending_bytes = {pending_bytes, e};
        endfunction

        // One frame forward; frames wrap on their own 5 bits without carry.
        function void step_frame();
            logic [4:0] fps;
            fps = (rate == RATE_24) ? 5'd24 : (rate == RATE_25) ? 5'd25 : 5'd30;
            tc.frames = tc.frames + 5'd1;
            if (tc.frames < fps) return;
            tc.frames = 5'd0;
            tc.seconds = tc.seconds + 6'd1;
            if (tc.seconds >= 6'd60) begin
                tc.seconds = 6'd0;
                tc.minutes = tc.minutes + 6'd1;
                if (tc.minutes >= 6'd60) begin
                    tc.minutes = 6'd0;
                    tc.hours = tc.hours + 5'd1;
                    if (tc.hours >= 5'd24) tc.hours = 5'd0;
                end
            end
            if (rate == RATE_30_DROP && tc.seconds == 6'd0 && (tc.minutes % 6'd10) != 6'd0)
                tc.frames = 5'd2;
        endfunction

        function void predict_item(logic mode, logic [4:0] h, logic [5:0] m,
                                   logic [5:0] s, logic [4:0] f);
            logic [4:0]  hr;
            logic [23:0] eff;
            logic [7:0]  hrbits;
            logic [3:0]  nib;
            logic [24:0] acc;
            if (mode) begin
                hr = h % 5'd24;
                push_byte(BYTE_SYSEX_START, 1'b0);
                push_byte(BYTE_UNIVERSAL_RT, 1'b0);
                push_byte(BYTE_UNIVERSAL_RT, 1'b0);
                push_byte(BYTE_MTC_SUB_ID, 1'b0);
                push_byte(BYTE_MTC_SUB_ID, 1'b0);
                push_byte({1'b0, rate, hr}, 1'b0);
                push_byte({2'b0, m}, 1'b0);
                push_byte({2'b0, s}, 1'b0);
                push_byte({3'b0, f}, 1'b0);
                push_byte(BYTE_SYSEX_END, 1'b1);
                tc.hours = hr;
                tc.minutes = m;
                tc.seconds = s;
                tc.frames = f;
                // start the quarter-frame group on an even frame
                if (rate != RATE_25 && f[0]) step_frame();
                piece = '0;
                phase = '0;
                running = 1'b1;
                loads++;
                return;
            end
            if (!running || !qf_en) return;
            eff = (period < PHASE_STEP) ? PHASE_STEP : period;
            acc = {1'b0, phase};
            if (phase < PHASE_STEP) begin
                hrbits = {1'b0, rate, tc.hours};
                case (piece)
                    PIECE_FRAMES_LO:  nib = tc.frames[3:0];
                    PIECE_FRAMES_HI:  nib = {3'b0, tc.frames[4]};
                    PIECE_SECONDS_LO: nib = tc.seconds[3:0];
                    PIECE_SECONDS_HI: nib = {2'b0, tc.seconds[5:4]};
                    PIECE_MINUTES_LO: nib = tc.minutes[3:0];
                    PIECE_MINUTES_HI: nib = {2'b0, tc.minutes[5:4]};
                    PIECE_HOURS_LO:   nib = hrbits[3:0];
                    default:          nib = hrbits[7:4];
                endcase
                push_byte(BYTE_QF_STATUS, 1'b0);
                push_byte({1'b0, piece, nib}, 1'b1);
                quarter_frames++;
                piece = piece + 3'd1;
                if (piece == 3'd0) begin
                    step_frame();
                    step_frame();
                end
                acc = acc + {1'b0, eff};
            end
            acc = acc - {1'b0, PHASE_STEP};
            phase = acc[23:0];
        endfunction

        function void check_byte(logic [7:0] b, logic l);
            t_mtc_byte e;
            bytes_checked++;
            if (pending_bytes.size() == 0) begin
                $error("unexpected byte: midi_byte %02h last %0d", b, l);
                errors++;
                return;
            end
            e = pending_bytes.pop_front();
            if (b !== e.midi_byte) begin
                $error("midi_byte: expected %02h, actual %02h", e.midi_byte, b);
                errors++;
            end
            if (l !== e.last) begin
                $error("last: expected %0d, actual %0d", e.last, l);
                errors++;
            end
        endfunction
    endclass

    timecode_scoreboard sb = new();
    int cycles = 0;
    int settings = 0;
    int stall_mode = 0;
    int stall_left = 0;

    mtc_quarter_frame_generator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_tc_hours   (i_tc_hours),
        .i_tc_minutes (i_tc_minutes),
        .i_tc_seconds (i_tc_seconds),
        .i_tc_frames  (i_tc_frames),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_midi_byte  (o_midi_byte),
        .o_last       (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d bytes outstanding",
                     cycles, sb.pending_bytes.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Output stall: switch among free-running, sparse, periodic and heavy patterns.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= cycles[2];
            default: i_out_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_byte(o_midi_byte, o_last);
    end

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic configure(input logic [1:0] rate, input logic [23:0] period,
                             input logic en);
        write_reg(CFG_RATE, {22'b0, rate});
        write_reg(CFG_PERIOD, period);
        write_reg(CFG_QF_EN, {23'b0, en});
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    // Hold the item until the transfer; valid stays high for a following item.
    task automatic send_item(input logic mode, input logic [4:0] h, input logic [5:0] m,
                             input logic [5:0] s, input logic [4:0] f);
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_tc_hours <= h;
        i_tc_minutes <= m;
        i_tc_seconds <= s;
        i_tc_frames <= f;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.predict_item(mode, h, m, s, f);
    endtask

    task automatic tick();
        send_item(1'b0, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                  6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        int         sent;
        int         burst;
        int         gap;
        logic       mode;
        logic [4:0] h;
        logic [5:0] m;
        logic [5:0] s;
        logic [4:0] f;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < count; k++) begin
                mode = ($urandom_range(0, 9) == 0);
                if (mode && $urandom_range(0, 3) == 0) begin
                    h = 5'($urandom_range(0, 31));
                    m = 6'($urandom_range(0, 63));
                    s = 6'($urandom_range(0, 63));
                    f = 5'($urandom_range(0, 31));
                end else if (mode) begin
                    // lean toward carries across seconds and minutes
                    h = 5'($urandom_range(0, 23));
                    m = $urandom_range(0, 1) ? 6'(59 - 50 * $urandom_range(0, 1))
                                             : 6'($urandom_range(0, 59));
                    s = $urandom_range(0, 1) ? 6'd59 : 6'($urandom_range(0, 59));
                    f = $urandom_range(0, 1) ? 5'($urandom_range(20, 29))
                                             : 5'($urandom_range(0, 29));
                end else begin
                    h = 5'($urandom_range(0, 31));
                    m = 6'($urandom_range(0, 63));
                    s = 6'($urandom_range(0, 63));
                    f = 5'($urandom_range(0, 31));
                end
                send_item(mode, h, m, s, f);
                sent++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        logic [23:0] period;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // short period at 30 fps: ticks before any load do nothing
        configure(RATE_30, 24'd0, 1'b1);
        tick();
        tick();
        // out-of-range load: hours reduce, odd frame bumps to even
        send_item(1'b1, 5'd31, 6'd63, 6'd63, 5'd31);
        repeat (9) tick();
        wait_idle();

        // drop frame: group wrap into minute one lands on frame 2
        configure(RATE_30_DROP, 24'd256, 1'b1);
        send_item(1'b1, 5'd0, 6'd0, 6'd59, 5'd28);
        repeat (8) tick();
        wait_idle();

        // 24 fps wrap at midnight, disabled ticks, then the longest period
        configure(RATE_24, 24'hFFFFFF, 1'b0);
        send_item(1'b1, 5'd23, 6'd59, 6'd59, 5'd23);
        tick();
        wait_idle();
        configure(RATE_24, 24'hFFFFFF, 1'b1);
        tick();
        tick();
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            case ($urandom_range(0, 9))
                0: period = 24'($urandom_range(0, 255));
                1: period = 24'hFFFFFF;
                default: period = 24'($urandom_range(256, 1280));
            endcase
            configure(2'($urandom_range(0, 3)), period, $urandom_range(0, 4) != 0);
            run_random(33);
            wait_idle();
        end

        sb.errors += sb.pending_bytes.size();
        $display("Covered %0d loads and %0d quarter frames over %0d register settings",
                 sb.loads, sb.quarter_frames, settings);
        $display("Checked %0d output bytes in %0d cycles", sb.bytes_checked, cycles);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
